@@ sv/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg: shared types and helpers for the slave serial config sequencer
// Holds the counter width, register index codes, request and result structs,
// and limit helpers used by the sequencer core.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Width of the shared hold/timeout counter (range 8 to 32)
  localparam int unsigned TIMEOUT_BITS = 24;
  localparam int unsigned CNT_W        = TIMEOUT_BITS;
  // Widest configuration register
  localparam int unsigned REG_W        = 24;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned EXT_W        = 33;

  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  // Register index codes
  typedef enum logic [IDX_W-1:0] {
    CFG_PROG_HIGH_TICKS   = 3'd0,
    CFG_PROG_LOW_TICKS    = 3'd1,
    CFG_INIT_LOW_TIMEOUT  = 3'd2,
    CFG_SETTLE_TICKS      = 3'd3,
    CFG_INIT_HIGH_TIMEOUT = 3'd4,
    CFG_TRAILING_CLOCKS   = 3'd5
  } cfg_idx_t;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PROG_HIGH = 4'd1,
    PH_PROG_LOW  = 4'd2,
    PH_WAIT_LOW  = 4'd3,
    PH_SETTLE    = 4'd4,
    PH_WAIT_HIGH = 4'd5,
    PH_LOAD      = 4'd6,
    PH_SHIFT     = 4'd7,
    PH_TRAIL     = 4'd8
  } phase_t;

  // Final status codes
  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_INIT_NOT_LOW  = 2'd1,
    ST_INIT_NOT_HIGH = 2'd2,
    ST_DONE_LOW      = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  prog_high_ticks;
    logic [7:0]  prog_low_ticks;
    logic [15:0] init_low_timeout;
    logic [7:0]  settle_ticks;
    logic [23:0] init_high_timeout;
    logic [7:0]  trailing_clocks;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_last;
    logic       init_level;
    logic       done_level;
  } item_t;

  typedef struct packed {
    logic       prog_pin;
    logic       clock_pin;
    logic       data_pin;
    logic       byte_taken;
    logic       busy_res;
    logic       status_valid;
    logic [1:0] status_code;
  } result_t;

  // Clamp a limit to the counter's maximum
  function automatic cnt_t clamp_limit(input logic [REG_W-1:0] limit);
    logic [EXT_W-1:0] lim_x;
    logic [EXT_W-1:0] max_x;
    lim_x = EXT_W'(limit);
    max_x = EXT_W'(CNT_MAX);
    return (lim_x > max_x) ? CNT_MAX : CNT_W'(limit);
  endfunction

  // Hold limit: a zero count acts like one
  function automatic cnt_t hold_limit(input logic [REG_W-1:0] limit);
    logic [REG_W-1:0] lim1;
    lim1 = (limit == '0) ? REG_W'(1) : limit;
    return clamp_limit(lim1);
  endfunction

  // Saturating counter increment
  function automatic cnt_t cnt_bump(input cnt_t cnt);
    return (cnt != CNT_MAX) ? cnt + CNT_W'(1) : cnt;
  endfunction

endpackage

@@ sv/scs_ifs.sv @@
// ----------------------------------------------------------------------------
// scs_ifs: request and result channel interfaces
// Valid/ready channels carrying one tick request and one pin-level result.
// ----------------------------------------------------------------------------
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic       byte_last;
  logic       init_level;
  logic       done_level;

  modport source (
    output valid, start_req, byte_valid, byte_value, byte_last, init_level, done_level,
    input  ready
  );
  modport sink (
    input  valid, start_req, byte_valid, byte_value, byte_last, init_level, done_level,
    output ready
  );
endinterface

interface scs_out_if;
  logic       valid;
  logic       ready;
  logic       prog_pin;
  logic       clock_pin;
  logic       data_pin;
  logic       byte_taken;
  logic       busy_res;
  logic       status_valid;
  logic [1:0] status_code;

  modport source (
    output valid, prog_pin, clock_pin, data_pin, byte_taken, busy_res, status_valid,
           status_code,
    input  ready
  );
  modport sink (
    input  valid, prog_pin, clock_pin, data_pin, byte_taken, busy_res, status_valid,
           status_code,
    output ready
  );
endinterface

@@ sv/scs_cfg.sv @@
// ----------------------------------------------------------------------------
// scs_cfg: configuration register file
// Write-only timing registers, loaded by index, with their reset defaults.
// ----------------------------------------------------------------------------
module scs_cfg import scs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_PROG_HIGH_TICKS:   cfg_nxt.prog_high_ticks   = cfg_wdata[7:0];
        CFG_PROG_LOW_TICKS:    cfg_nxt.prog_low_ticks    = cfg_wdata[7:0];
        CFG_INIT_LOW_TIMEOUT:  cfg_nxt.init_low_timeout  = cfg_wdata[15:0];
        CFG_SETTLE_TICKS:      cfg_nxt.settle_ticks      = cfg_wdata[7:0];
        CFG_INIT_HIGH_TIMEOUT: cfg_nxt.init_high_timeout = cfg_wdata[23:0];
        CFG_TRAILING_CLOCKS:   cfg_nxt.trailing_clocks   = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prog_high_ticks   <= 8'd10;
      cfg_r.prog_low_ticks    <= 8'd5;
      cfg_r.init_low_timeout  <= 16'd200;
      cfg_r.settle_ticks      <= 8'd5;
      cfg_r.init_high_timeout <= 24'hFFFFFF;
      cfg_r.trailing_clocks   <= 8'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/scs_core.sv @@
// ----------------------------------------------------------------------------
// scs_core: sequencer state and one-tick step logic
// Holds phase, counter, shifter and pin levels; advances one tick per step.
// ----------------------------------------------------------------------------
module scs_core import scs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t     phase_r, phase_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bits_r, bits_nxt;
  logic       half_r, half_nxt;
  logic       final_r, final_nxt;
  logic       prog_r, prog_nxt;
  logic       clk_pin_r, clk_pin_nxt;
  logic       data_r, data_nxt;

  cnt_t       cnt_inc;
  logic       taken;
  logic       fin;
  status_t    code;
  logic       last_bit_end;

  assign cnt_inc      = cnt_bump(cnt_r);
  assign last_bit_end = half_r && (bits_r == 4'd0) && !final_r;

  // Result flags: byte taken, sequence end and its status
  always_comb begin
    taken = 1'b0;
    fin   = 1'b0;
    code  = ST_OK;
    case (phase_r)
      PH_LOAD:  taken = item.byte_valid;
      PH_SHIFT: taken = last_bit_end && item.byte_valid;
      PH_WAIT_LOW: begin
        if (item.init_level &&
            cnt_inc >= clamp_limit(REG_W'(cfg.init_low_timeout))) begin
          fin  = 1'b1;
          code = ST_INIT_NOT_LOW;
        end
      end
      PH_WAIT_HIGH: begin
        if (!item.init_level &&
            cnt_inc >= clamp_limit(REG_W'(cfg.init_high_timeout))) begin
          fin  = 1'b1;
          code = ST_INIT_NOT_HIGH;
        end
      end
      PH_TRAIL: begin
        if (!half_r && cnt_r >= CNT_W'(cfg.trailing_clocks)) begin
          fin  = 1'b1;
          code = item.done_level ? ST_OK : ST_DONE_LOW;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    half_nxt    = half_r;
    final_nxt   = final_r;
    prog_nxt    = prog_r;
    clk_pin_nxt = clk_pin_r;
    data_nxt    = data_r;
    case (phase_r)
      PH_IDLE: begin
        prog_nxt    = 1'b1;
        clk_pin_nxt = 1'b0;
        data_nxt    = 1'b0;
        if (item.start_req) begin
          phase_nxt = PH_PROG_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_PROG_HIGH: begin
        prog_nxt = 1'b1;
        cnt_nxt  = cnt_inc;
        if (cnt_inc >= hold_limit(REG_W'(cfg.prog_high_ticks))) begin
          prog_nxt  = 1'b0;
          phase_nxt = PH_PROG_LOW;
          cnt_nxt   = '0;
        end
      end
      PH_PROG_LOW: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= hold_limit(REG_W'(cfg.prog_low_ticks))) begin
          phase_nxt = PH_WAIT_LOW;
          cnt_nxt   = '0;
        end
      end
      PH_WAIT_LOW: begin
        if (!item.init_level) begin
          phase_nxt = PH_SETTLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_SETTLE: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= hold_limit(REG_W'(cfg.settle_ticks))) begin
          prog_nxt  = 1'b1;
          phase_nxt = PH_WAIT_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_WAIT_HIGH: begin
        if (item.init_level) begin
          phase_nxt = PH_LOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_LOAD, PH_SHIFT: begin
        if (phase_r == PH_SHIFT && !half_r) begin
          // Rising half of a bit: raise CCLK and shift
          clk_pin_nxt = 1'b1;
          half_nxt    = 1'b1;
          shift_nxt   = {shift_r[6:0], 1'b0};
          if (bits_r != 4'd0) bits_nxt = bits_r - 4'd1;
        end else if (phase_r == PH_SHIFT && bits_r != 4'd0) begin
          // Falling half: present the next bit
          clk_pin_nxt = 1'b0;
          half_nxt    = 1'b0;
          data_nxt    = shift_r[7];
        end else if (phase_r == PH_SHIFT && final_r) begin
          clk_pin_nxt = 1'b0;
          half_nxt    = 1'b0;
          phase_nxt   = PH_TRAIL;
          cnt_nxt     = '0;
        end else begin
          // Wait for data, or take the next byte at the end of the last bit
          half_nxt    = 1'b0;
          phase_nxt   = PH_LOAD;
          clk_pin_nxt = 1'b0;
          if (item.byte_valid) begin
            shift_nxt = item.byte_value;
            bits_nxt  = 4'd8;
            final_nxt = item.byte_last;
            data_nxt  = item.byte_value[7];
            phase_nxt = PH_SHIFT;
          end
        end
      end
      PH_TRAIL: begin
        if (half_r) begin
          clk_pin_nxt = 1'b0;
          half_nxt    = 1'b0;
        end else if (!fin) begin
          clk_pin_nxt = 1'b1;
          half_nxt    = 1'b1;
          cnt_nxt     = cnt_inc;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
    // Drop back to idle with safe pin levels on any ending tick
    if (fin) begin
      prog_nxt    = 1'b1;
      clk_pin_nxt = 1'b0;
      data_nxt    = 1'b0;
      phase_nxt   = PH_IDLE;
      cnt_nxt     = '0;
      bits_nxt    = 4'd0;
      half_nxt    = 1'b0;
      final_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      shift_r   <= 8'd0;
      bits_r    <= 4'd0;
      half_r    <= 1'b0;
      final_r   <= 1'b0;
      prog_r    <= 1'b1;
      clk_pin_r <= 1'b0;
      data_r    <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      shift_r   <= shift_nxt;
      bits_r    <= bits_nxt;
      half_r    <= half_nxt;
      final_r   <= final_nxt;
      prog_r    <= prog_nxt;
      clk_pin_r <= clk_pin_nxt;
      data_r    <= data_nxt;
    end
  end

  // Result of this tick
  always_comb begin
    res.prog_pin     = prog_nxt;
    res.clock_pin    = clk_pin_nxt;
    res.data_pin     = data_nxt;
    res.byte_taken   = taken;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.status_valid = fin;
    res.status_code  = code;
  end

endmodule

@@ sv/fpga_serial_config_sequencer.sv @@
// ----------------------------------------------------------------------------
// fpga_serial_config_sequencer: slave serial configuration pin sequencer
// Input register, one-tick sequencer step and result register.
// ----------------------------------------------------------------------------
// Each request is one tick of sampled INIT_B/DONE levels, a start flag and an
// offered bitstream byte; each yields exactly one result with the PROG_B,
// CCLK and DIN levels, byte acceptance, busy and the end status. The block
// takes one request per clock as long as results are taken. A request is held in
// the input register while the sequencer steps on it; its result is captured in
// the result register (one input register, one result register) and waits
// there until taken. The sequencer state updates once per request in a single
// pass between these registers.
// Write configuration registers only while no sequence is running.
module fpga_serial_config_sequencer import scs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  scs_in_if.sink           in_ch,
  scs_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    step;
  logic    in_acc;

  scs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance when a request is held and the result slot is free
  assign step         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.start_req  <= in_ch.start_req;
      item_r.byte_valid <= in_ch.byte_valid;
      item_r.byte_value <= in_ch.byte_value;
      item_r.byte_last  <= in_ch.byte_last;
      item_r.init_level <= in_ch.init_level;
      item_r.done_level <= in_ch.done_level;
    end
  end

  scs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.prog_pin     = res_r.prog_pin;
  assign out_ch.clock_pin    = res_r.clock_pin;
  assign out_ch.data_pin     = res_r.data_pin;
  assign out_ch.byte_taken   = res_r.byte_taken;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.status_valid = res_r.status_valid;
  assign out_ch.status_code  = res_r.status_code;

endmodule

@@ sv/scs_checker.sv @@
// ----------------------------------------------------------------------------
// scs_checker: port-level checks for the configuration sequencer
// Watches the result channel for pin and status consistency.
// ----------------------------------------------------------------------------
module scs_checker import scs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       prog_pin,
  input logic       clock_pin,
  input logic       data_pin,
  input logic       byte_taken,
  input logic       busy_res,
  input logic       status_valid,
  input logic [1:0] status_code
);

  // An ending tick leaves the pins safe and the block idle
  a_end_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_valid |-> prog_pin && !clock_pin && !data_pin && !busy_res)
    else $error("ending request left pins or busy active");

  // A nonzero status only comes with an ending tick
  a_code_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_code != ST_OK |-> status_valid)
    else $error("status code without status valid");

  // A byte is only taken during loading with CCLK low
  a_take_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_taken |-> busy_res && !clock_pin && prog_pin && !status_valid)
    else $error("byte taken outside loading");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({prog_pin, clock_pin, data_pin,
      byte_taken, busy_res, status_valid, status_code}))
    else $error("stalled result changed");

endmodule

bind fpga_serial_config_sequencer scs_checker u_scs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .prog_pin     (out_ch.prog_pin),
  .clock_pin    (out_ch.clock_pin),
  .data_pin     (out_ch.data_pin),
  .byte_taken   (out_ch.byte_taken),
  .busy_res     (out_ch.busy_res),
  .status_valid (out_ch.status_valid),
  .status_code  (out_ch.status_code)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the slave serial configuration sequencer
// Drives tick requests over the valid/ready request channel and keeps a cycle
// model of the sequencer that predicts the pin-level result for each request.
// The stimulus plays the part of the FPGA: INIT_B, DONE and the bitstream bytes
// follow the phase the model is in. Directed tests cover reset values, zero and
// maximum register values, timeout edges, DONE low and byte patterns. Random
// sequences and noise follow, with random idle cycles on both channel sides.
// ----------------------------------------------------------------------------
module tb_top;
  import scs_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0] cfg_wdata;

  scs_in_if  in_ch();
  scs_out_if out_ch();

  fpga_serial_config_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sequencer model state
  cfg_t       cfg_m;
  phase_t     ph_m;
  cnt_t       cnt_m;
  logic [7:0] shreg_m;
  logic [3:0] bits_m;
  logic       hi_half_m;
  logic       last_m;
  logic       prog_m;
  logic       clk_m;
  logic       din_m;

  // Expected pin results, oldest first
  result_t    pin_results_q[$];
  int         n_mismatch = 0;
  int         n_sent = 0;

  // Behavior of the emulated FPGA and the bitstream source
  int         fall_after_gen = 0;
  int         rise_after_gen = 0;
  int         offer_pct_gen = 100;
  int         bytes_total_gen = 1;
  int         bytes_sent_gen = 0;
  bit         done_ok_gen = 1'b1;
  logic [7:0] byte_pat_q[$];

  // Idle control for both channel sides
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         rx_hold_cycles = 0;

  // Advance the counter, saturating at its top value
  function automatic void count_tick();
    if (cnt_m != CNT_MAX) cnt_m = cnt_m + 1'b1;
  endfunction

  // Limit a register value to what the counter can reach
  function automatic cnt_t cap_limit(input logic [23:0] lim);
    if (longint'(lim) > longint'(CNT_MAX)) return CNT_MAX;
    return CNT_W'(lim);
  endfunction

  // Count one hold tick; a zero count holds for one tick
  function automatic bit hold_elapsed(input logic [23:0] lim);
    cnt_t l;
    l = cap_limit((lim == 24'd0) ? 24'd1 : lim);
    count_tick();
    return cnt_m >= l;
  endfunction

  // Wait for data with CCLK low; take an offered byte and present its MSB
  function automatic bit grab_byte(input item_t rq);
    ph_m = PH_LOAD;
    clk_m = 1'b0;
    if (!rq.byte_valid) return 1'b0;
    shreg_m = rq.byte_value;
    bits_m = 4'd8;
    last_m = rq.byte_last;
    hi_half_m = 1'b0;
    din_m = shreg_m[7];
    ph_m = PH_SHIFT;
    return 1'b1;
  endfunction

  // Apply one tick request to the model and return the pin result
  function automatic result_t step_sequencer(input item_t rq);
    result_t r;
    bit      taken;
    bit      fin;
    status_t code;
    taken = 1'b0;
    fin = 1'b0;
    code = ST_OK;
    case (ph_m)
      PH_IDLE: begin
        prog_m = 1'b1;
        clk_m = 1'b0;
        din_m = 1'b0;
        if (rq.start_req) begin
          ph_m = PH_PROG_HIGH;
          cnt_m = '0;
        end
      end
      PH_PROG_HIGH: begin
        prog_m = 1'b1;
        if (hold_elapsed(24'(cfg_m.prog_high_ticks))) begin
          prog_m = 1'b0;
          ph_m = PH_PROG_LOW;
          cnt_m = '0;
        end
      end
      PH_PROG_LOW: begin
        if (hold_elapsed(24'(cfg_m.prog_low_ticks))) begin
          ph_m = PH_WAIT_LOW;
          cnt_m = '0;
        end
      end
      PH_WAIT_LOW: begin
        if (!rq.init_level) begin
          ph_m = PH_SETTLE;
          cnt_m = '0;
        end else begin
          count_tick();
          if (cnt_m >= cap_limit(24'(cfg_m.init_low_timeout))) begin
            fin = 1'b1;
            code = ST_INIT_NOT_LOW;
          end
        end
      end
      PH_SETTLE: begin
        if (hold_elapsed(24'(cfg_m.settle_ticks))) begin
          prog_m = 1'b1;
          ph_m = PH_WAIT_HIGH;
          cnt_m = '0;
        end
      end
      PH_WAIT_HIGH: begin
        if (rq.init_level) begin
          ph_m = PH_LOAD;
          cnt_m = '0;
        end else begin
          count_tick();
          if (cnt_m >= cap_limit(cfg_m.init_high_timeout)) begin
            fin = 1'b1;
            code = ST_INIT_NOT_HIGH;
          end
        end
      end
      PH_LOAD: begin
        taken = grab_byte(rq);
      end
      PH_SHIFT: begin
        if (!hi_half_m) begin
          // raise CCLK and move to the next bit
          clk_m = 1'b1;
          hi_half_m = 1'b1;
          shreg_m = shreg_m << 1;
          if (bits_m > 0) bits_m = bits_m - 1'b1;
        end else if (bits_m > 0) begin
          clk_m = 1'b0;
          hi_half_m = 1'b0;
          din_m = shreg_m[7];
        end else if (last_m) begin
          clk_m = 1'b0;
          hi_half_m = 1'b0;
          ph_m = PH_TRAIL;
          cnt_m = '0;
        end else begin
          // end of byte doubles as the low half of the next byte's first bit
          hi_half_m = 1'b0;
          taken = grab_byte(rq);
        end
      end
      PH_TRAIL: begin
        if (hi_half_m) begin
          clk_m = 1'b0;
          hi_half_m = 1'b0;
        end else if (cnt_m >= cfg_m.trailing_clocks) begin
          fin = 1'b1;
          code = rq.done_level ? ST_OK : ST_DONE_LOW;
        end else begin
          clk_m = 1'b1;
          hi_half_m = 1'b1;
          count_tick();
        end
      end
      default: begin
        ph_m = PH_IDLE;
      end
    endcase

    // Park the pins and return to idle on an ending tick
    if (fin) begin
      prog_m = 1'b1;
      clk_m = 1'b0;
      din_m = 1'b0;
      ph_m = PH_IDLE;
      cnt_m = '0;
      bits_m = '0;
      hi_half_m = 1'b0;
      last_m = 1'b0;
    end

    r.prog_pin = prog_m;
    r.clock_pin = clk_m;
    r.data_pin = din_m;
    r.byte_taken = taken;
    r.busy_res = (ph_m != PH_IDLE);
    r.status_valid = fin;
    r.status_code = fin ? code : ST_OK;
    return r;
  endfunction

  // Build the next request from the phase the model is in
  function automatic item_t make_request(input bit begin_seq);
    item_t      rq;
    logic [12:0] raw;
    bit         window;
    raw = 13'($urandom);
    rq = raw;
    window = (ph_m == PH_LOAD) ||
             (ph_m == PH_SHIFT && hi_half_m && bits_m == 0 && !last_m);
    case (ph_m)
      PH_IDLE: begin
        rq.start_req = begin_seq;
      end
      PH_WAIT_LOW: begin
        rq.init_level = (cnt_m < fall_after_gen);
      end
      PH_WAIT_HIGH: begin
        rq.init_level = (cnt_m >= rise_after_gen);
      end
      PH_TRAIL: begin
        rq.done_level = done_ok_gen;
      end
      default: ;
    endcase
    if (window) begin
      rq.byte_valid = ($urandom_range(1, 100) <= offer_pct_gen);
      rq.byte_last = (bytes_sent_gen + 1 >= bytes_total_gen);
      if (byte_pat_q.size() > 0) rq.byte_value = byte_pat_q[0];
    end
    return rq;
  endfunction

  // Offer one request, wait for it to be taken and record its expected result
  task automatic send_request(input item_t rq);
    int      gap;
    result_t want;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_req  <= rq.start_req;
    in_ch.byte_valid <= rq.byte_valid;
    in_ch.byte_value <= rq.byte_value;
    in_ch.byte_last  <= rq.byte_last;
    in_ch.init_level <= rq.init_level;
    in_ch.done_level <= rq.done_level;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = step_sequencer(rq);
    if (want.byte_taken) begin
      bytes_sent_gen++;
      if (byte_pat_q.size() > 0) void'(byte_pat_q.pop_front());
    end
    pin_results_q.push_back(want);
    n_sent++;
  endtask

  // Drop valid and hold until every expected result has come out
  task automatic wait_results_drained(input int extra);
    in_ch.valid <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write one configuration register and mirror it in the model
  task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PROG_HIGH_TICKS:   cfg_m.prog_high_ticks = val[7:0];
      CFG_PROG_LOW_TICKS:    cfg_m.prog_low_ticks = val[7:0];
      CFG_INIT_LOW_TIMEOUT:  cfg_m.init_low_timeout = val[15:0];
      CFG_SETTLE_TICKS:      cfg_m.settle_ticks = val[7:0];
      CFG_INIT_HIGH_TIMEOUT: cfg_m.init_high_timeout = val[23:0];
      CFG_TRAILING_CLOCKS:   cfg_m.trailing_clocks = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input int ph, input int pl, input int il, input int st,
                             input int ih, input int tr);
    write_reg(CFG_PROG_HIGH_TICKS, REG_W'(ph));
    write_reg(CFG_PROG_LOW_TICKS, REG_W'(pl));
    write_reg(CFG_INIT_LOW_TIMEOUT, REG_W'(il));
    write_reg(CFG_SETTLE_TICKS, REG_W'(st));
    write_reg(CFG_INIT_HIGH_TIMEOUT, REG_W'(ih));
    write_reg(CFG_TRAILING_CLOCKS, REG_W'(tr));
  endtask

  // Run one configuration sequence from idle back to idle; pause_at > 0
  // makes the sender hold after that many requests until all results are in
  task automatic run_sequence(input int n_bytes, input int fall_after, input int rise_after,
                              input bit done_ok, input int offer_pct, input int pause_at);
    int cnt;
    fall_after_gen = fall_after;
    rise_after_gen = rise_after;
    done_ok_gen = done_ok;
    offer_pct_gen = offer_pct;
    bytes_total_gen = n_bytes;
    bytes_sent_gen = 0;
    cnt = 1;
    send_request(make_request(1'b1));
    while (ph_m != PH_IDLE) begin
      if (cnt == pause_at) wait_results_drained(2);
      send_request(make_request(1'b0));
      cnt++;
    end
  endtask

  // Steer a running sequence to its end by the shortest path
  task automatic wind_down();
    fall_after_gen = 0;
    rise_after_gen = 0;
    offer_pct_gen = 100;
    bytes_sent_gen = 0;
    bytes_total_gen = 1;
    done_ok_gen = 1'($urandom_range(0, 1));
    while (ph_m != PH_IDLE) send_request(make_request(1'b0));
  endtask

  // Reset register values, idle requests with stray bytes, one full sequence
  task automatic test_reset_values();
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    repeat (3) send_request(make_request(1'b0));
    run_sequence(1, 3, 2, 1'b1, 100, -1);
    wait_results_drained(4);
  endtask

  // All registers zero: holds act as one tick, timeouts fail on first miss
  task automatic test_zero_counts();
    tx_steady = 1'b0;
    load_config(0, 0, 0, 0, 0, 0);
    run_sequence(1, 0, 0, 1'b1, 100, -1);
    run_sequence(1, 1, 0, 1'b1, 100, -1);
    run_sequence(1, 0, 1, 1'b1, 100, -1);
    wait_results_drained(4);
  endtask

  // INIT_B just inside and just past each timeout
  task automatic test_timeout_edges();
    load_config(1, 2, 3, 1, 4, 1);
    run_sequence(1, 2, 3, 1'b1, 100, -1);
    run_sequence(1, 3, 0, 1'b1, 100, -1);
    run_sequence(1, 0, 4, 1'b1, 100, -1);
    wait_results_drained(4);
  endtask

  // Byte extremes back to back with DONE low, then a sparse byte source
  task automatic test_byte_patterns();
    load_config(2, 1, 10, 2, 10, 3);
    tx_steady = 1'b1;
    byte_pat_q = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h5A};
    run_sequence(5, 1, 1, 1'b0, 100, -1);
    tx_steady = 1'b0;
    run_sequence(2, 2, 1, 1'b1, 40, -1);
    wait_results_drained(4);
  endtask

  // Full-scale timeouts and the longest program-high hold
  task automatic test_max_config();
    load_config(255, 1, 65535, 1, 16777215, 1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_sequence(2, 5, 5, 1'b1, 100, -1);
    wait_results_drained(4);
  endtask

  // Hold off the result side long enough to stall requests, then pause the
  // sender mid-sequence until the pipe is empty
  task automatic test_backpressure();
    load_config(3, 2, 6, 2, 6, 4);
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    rx_hold_cycles = 300;
    run_sequence(2, 2, 2, 1'b1, 100, -1);
    tx_steady = 1'b0;
    run_sequence(3, 1, 2, 1'b1, 80, 20);
    wait_results_drained(4);
  endtask

  // Random settings, mostly well-formed sequences, some noise bursts
  task automatic test_random_traffic();
    logic [12:0] raw;
    int          mark;
    for (int p = 0; p < 2; p++) begin
      wait_results_drained(4);
      load_config($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 6),
                  $urandom_range(0, 4), $urandom_range(0, 6), $urandom_range(0, 8));
      mark = n_sent;
      while (n_sent - mark < 50) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(5, 25)) begin
            raw = 13'($urandom);
            send_request(raw);
          end
          wind_down();
        end else begin
          run_sequence($urandom_range(1, 3), $urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 3) != 0, $urandom_range(30, 100), -1);
        end
      end
    end
  endtask

  // Result side: random ready gaps, plus a long hold when requested
  initial begin : result_ready
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1 && rx_hold_cycles == 0);
    end
  end

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] got);
    if (got !== want) begin
      n_mismatch++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pin_results_q.size() == 0) begin
        n_mismatch++;
        $display("%0t: result with none expected, expected none, actual prog %0b clk %0b",
                 $time, out_ch.prog_pin, out_ch.clock_pin);
      end else begin
        want = pin_results_q.pop_front();
        check_field("prog_pin", 2'(want.prog_pin), 2'(out_ch.prog_pin));
        check_field("clock_pin", 2'(want.clock_pin), 2'(out_ch.clock_pin));
        check_field("data_pin", 2'(want.data_pin), 2'(out_ch.data_pin));
        check_field("byte_taken", 2'(want.byte_taken), 2'(out_ch.byte_taken));
        check_field("busy_res", 2'(want.busy_res), 2'(out_ch.busy_res));
        check_field("status_valid", 2'(want.status_valid), 2'(out_ch.status_valid));
        check_field("status_code", want.status_code, out_ch.status_code);
      end
    end
  end

  // Run limit
  initial begin : run_limit
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    // drive every input to a known level
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_PROG_HIGH_TICKS;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.start_req  <= 1'b0;
    in_ch.byte_valid <= 1'b0;
    in_ch.byte_value <= 8'h00;
    in_ch.byte_last  <= 1'b0;
    in_ch.init_level <= 1'b1;
    in_ch.done_level <= 1'b0;

    // model state after reset
    cfg_m.prog_high_ticks   = 8'd10;
    cfg_m.prog_low_ticks    = 8'd5;
    cfg_m.init_low_timeout  = 16'd200;
    cfg_m.settle_ticks      = 8'd5;
    cfg_m.init_high_timeout = 24'hFFFFFF;
    cfg_m.trailing_clocks   = 8'd50;
    ph_m      = PH_IDLE;
    cnt_m     = '0;
    shreg_m   = '0;
    bits_m    = '0;
    hi_half_m = 1'b0;
    last_m    = 1'b0;
    prog_m    = 1'b1;
    clk_m     = 1'b0;
    din_m     = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_zero_counts();
    test_timeout_edges();
    test_byte_patterns();
    test_max_config();
    test_backpressure();
    test_random_traffic();

    wait_results_drained(10);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
